// ===== design/ils_pkg.sv =====
// Shared types, codes and constants for the indexed list store.
`default_nettype none

package ils_pkg;

  localparam int CapacityDef  = 64;
  localparam int ValueBitsDef = 32;
  localparam int CmdW         = 3;
  localparam int PosW         = 7;
  localparam int ItemW        = 32;
  localparam int StatusW      = 2;
  localparam int FillW        = 7;

  typedef enum logic [CmdW-1:0] {
    CMD_PUSH    = 3'd0,
    CMD_POP     = 3'd1,
    CMD_SHIFT   = 3'd2,
    CMD_UNSHIFT = 3'd3,
    CMD_FETCH   = 3'd4,
    CMD_UPDATE  = 3'd5,
    CMD_INSERT  = 3'd6,
    CMD_DELETE  = 3'd7
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    RD_TOP    = 2'd0,
    RD_EFF    = 2'd1,
    RD_IDX_DN = 2'd2,
    RD_IDX_UP = 2'd3
  } rd_sel_e;

  typedef enum logic [1:0] {
    WR_COUNT = 2'd0,
    WR_EFF   = 2'd1,
    WR_IDX   = 2'd2
  } wr_sel_e;

  typedef struct packed {
    logic [CmdW-1:0]  cmd;
    logic [PosW-1:0]  position;
    logic [ItemW-1:0] item_value;
  } in_item_t;

  typedef struct packed {
    logic [ItemW-1:0]   read_value;
    logic [StatusW-1:0] status;
    logic [FillW-1:0]   fill_count;
  } out_item_t;

  typedef struct packed {
    logic    take;
    logic    judge;
    logic    capture;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    idx_load_cnt;
    logic    idx_load_pos;
    logic    idx_inc;
    logic    idx_dec;
    logic    ram_re;
    rd_sel_e rd_sel;
    logic    ram_we;
    wr_sel_e wr_sel;
    logic    wdata_from_ram;
    logic    publish;
  } ctrl_cmd_t;

  typedef struct packed {
    cmd_e cmd;
    logic range_err;
    logic full_err;
    logic ins_done;
    logic del_done;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== design/ils_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ils_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== design/ils_ctrl.sv =====
// Command sequencer for the indexed list store.
`default_nettype none

module ils_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire ils_pkg::dp_stat_t  stat_i,
  output ils_pkg::ctrl_cmd_t      cmd_o
);

  import ils_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_DECODE = 8'b0000_0010,
    S_READ   = 8'b0000_0100,
    S_INS_RD = 8'b0000_1000,
    S_INS_WR = 8'b0001_0000,
    S_DEL_RD = 8'b0010_0000,
    S_DEL_WR = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_e;

  state_e    state_q, state_d;
  ctrl_cmd_t c;

  always_comb begin
    state_d    = state_q;
    c          = '0;
    c.rd_sel   = RD_TOP;
    c.wr_sel   = WR_COUNT;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          c.take  = 1'b1;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        c.judge = 1'b1;
        if (stat_i.range_err || stat_i.full_err) begin
          state_d = S_DONE;
        end else begin
          unique case (stat_i.cmd)
            CMD_PUSH: begin
              c.ram_we  = 1'b1;
              c.wr_sel  = WR_COUNT;
              c.cnt_inc = 1'b1;
              state_d   = S_DONE;
            end
            CMD_UPDATE: begin
              c.ram_we = 1'b1;
              c.wr_sel = WR_EFF;
              state_d  = S_DONE;
            end
            CMD_POP: begin
              c.ram_re = 1'b1;
              c.rd_sel = RD_TOP;
              state_d  = S_READ;
            end
            CMD_FETCH, CMD_SHIFT: begin
              c.ram_re = 1'b1;
              c.rd_sel = RD_EFF;
              state_d  = S_READ;
            end
            CMD_UNSHIFT, CMD_INSERT: begin
              c.idx_load_cnt = 1'b1;
              state_d        = S_INS_RD;
            end
            CMD_DELETE: begin
              c.idx_load_pos = 1'b1;
              state_d        = S_DEL_RD;
            end
            default: state_d = S_DONE;
          endcase
        end
      end
      S_READ: begin
        c.capture = 1'b1;
        priority if (stat_i.cmd == CMD_POP) begin
          c.cnt_dec = 1'b1;
          state_d   = S_DONE;
        end else if (stat_i.cmd == CMD_SHIFT) begin
          c.idx_load_pos = 1'b1;
          state_d        = S_DEL_RD;
        end else begin
          state_d = S_DONE;
        end
      end
      S_INS_RD: begin
        if (stat_i.ins_done) begin
          c.ram_we  = 1'b1;
          c.wr_sel  = WR_EFF;
          c.cnt_inc = 1'b1;
          state_d   = S_DONE;
        end else begin
          c.ram_re = 1'b1;
          c.rd_sel = RD_IDX_DN;
          state_d  = S_INS_WR;
        end
      end
      S_INS_WR: begin
        c.ram_we         = 1'b1;
        c.wr_sel         = WR_IDX;
        c.wdata_from_ram = 1'b1;
        c.idx_dec        = 1'b1;
        state_d          = S_INS_RD;
      end
      S_DEL_RD: begin
        if (stat_i.del_done) begin
          c.cnt_dec = 1'b1;
          state_d   = S_DONE;
        end else begin
          c.ram_re = 1'b1;
          c.rd_sel = RD_IDX_UP;
          state_d  = S_DEL_WR;
        end
      end
      S_DEL_WR: begin
        c.ram_we         = 1'b1;
        c.wr_sel         = WR_IDX;
        c.wdata_from_ram = 1'b1;
        c.idx_inc        = 1'b1;
        state_d          = S_DEL_RD;
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          c.publish = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign cmd_o = c;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/ils_dpath.sv =====
// Datapath: held command, fill count, move index, entry RAM and result register.
`default_nettype none

module ils_dpath #(
  parameter int Capacity  = ils_pkg::CapacityDef,
  parameter int ValueBits = ils_pkg::ValueBitsDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire ils_pkg::in_item_t   in_item_i,
  input  wire logic                out_ready_i,
  output logic                     out_valid_o,
  output ils_pkg::out_item_t       out_item_o,
  input  wire ils_pkg::ctrl_cmd_t  cmd_i,
  output ils_pkg::dp_stat_t        stat_o
);

  import ils_pkg::*;

  localparam int AddrW     = $clog2(Capacity);
  localparam int CntW      = $clog2(Capacity + 1);
  localparam int CmpW      = (CntW > PosW) ? CntW : PosW;
  localparam int StoreBits = (ValueBits < ItemW) ? ValueBits : ItemW;

  in_item_t             item_q;
  logic [CntW-1:0]      count_q, count_d;
  logic [CntW-1:0]      idx_q, idx_d;
  logic [StoreBits-1:0] rd_q;
  status_e              st_q;
  logic                 out_valid_q;
  out_item_t            out_q;

  cmd_e                 cmd;
  logic [CmpW-1:0]      pos_x, eff_x, cnt_x, idx_x;
  logic                 range_err, full_err;
  logic [AddrW-1:0]     raddr, waddr;
  logic [StoreBits-1:0] wdata, rdata;
  logic [StoreBits-1:0] val;

  assign cmd   = cmd_e'(item_q.cmd);
  assign val   = item_q.item_value[StoreBits-1:0];
  assign pos_x = CmpW'(item_q.position);
  assign eff_x = ((cmd == CMD_UNSHIFT) || (cmd == CMD_SHIFT)) ? '0 : pos_x;
  assign cnt_x = CmpW'(count_q);
  assign idx_x = CmpW'(idx_q);

  always_comb begin
    range_err = 1'b0;
    unique case (cmd)
      CMD_POP, CMD_SHIFT:             range_err = (count_q == '0);
      CMD_FETCH, CMD_UPDATE, CMD_DELETE: range_err = (pos_x >= cnt_x);
      CMD_INSERT:                     range_err = (pos_x > cnt_x);
      default:                        range_err = 1'b0;
    endcase
  end

  assign full_err = !range_err && (count_q >= CntW'(Capacity)) &&
                    ((cmd == CMD_PUSH) || (cmd == CMD_UNSHIFT) || (cmd == CMD_INSERT));

  assign stat_o.cmd       = cmd;
  assign stat_o.range_err = range_err;
  assign stat_o.full_err  = full_err;
  assign stat_o.ins_done  = (idx_x == eff_x);
  assign stat_o.del_done  = ((idx_x + CmpW'(1)) >= cnt_x);
  assign stat_o.out_free  = !out_valid_q || out_ready_i;

  always_comb begin
    unique case (cmd_i.rd_sel)
      RD_TOP:    raddr = AddrW'(count_q - CntW'(1));
      RD_EFF:    raddr = AddrW'(eff_x);
      RD_IDX_DN: raddr = AddrW'(idx_q - CntW'(1));
      RD_IDX_UP: raddr = AddrW'(idx_q + CntW'(1));
      default:   raddr = '0;
    endcase
  end

  always_comb begin
    unique case (cmd_i.wr_sel)
      WR_COUNT: waddr = AddrW'(count_q);
      WR_EFF:   waddr = AddrW'(eff_x);
      WR_IDX:   waddr = AddrW'(idx_q);
      default:  waddr = '0;
    endcase
  end

  assign wdata = cmd_i.wdata_from_ram ? rdata : val;

  ils_ram #(
    .Width (StoreBits),
    .Depth (Capacity)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.ram_we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (cmd_i.ram_re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    count_d = count_q;
    priority if (cmd_i.cnt_inc) begin
      count_d = count_q + CntW'(1);
    end else if (cmd_i.cnt_dec) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_comb begin
    idx_d = idx_q;
    priority if (cmd_i.idx_load_cnt) begin
      idx_d = count_q;
    end else if (cmd_i.idx_load_pos) begin
      idx_d = CntW'(eff_x);
    end else if (cmd_i.idx_inc) begin
      idx_d = idx_q + CntW'(1);
    end else if (cmd_i.idx_dec) begin
      idx_d = idx_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      idx_q   <= idx_d;
      if (cmd_i.publish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      item_q <= in_item_i;
    end
    if (cmd_i.judge) begin
      rd_q <= '0;
      st_q <= range_err ? ST_RANGE : (full_err ? ST_FULL : ST_OK);
    end else if (cmd_i.capture) begin
      rd_q <= rdata;
    end
    if (cmd_i.publish) begin
      out_q.read_value <= ItemW'(rd_q);
      out_q.status     <= st_q;
      out_q.fill_count <= FillW'(count_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

// ===== design/indexed_list_store_top.sv =====
// Top level of the indexed list store: sequencer, datapath and entry RAM.
// An ordered list of up to CAPACITY value handles held in a RAM with one
// write and one registered read port, plus a fill count. One command is
// worked at a time. Push, update and any rejected command go from decode
// to the result beat; pop and fetch first read the RAM. Insert and unshift
// at index p move every entry from p up by one place, delete at p moves
// every entry after p down by one, and shift reads the head before a delete
// there: every entry moved by one place costs a RAM read and a RAM write.
// A finished result waits in the output register while the next command
// is taken. No clearing pass follows reset; unwritten entries are never read.
`default_nettype none

module indexed_list_store_top #(
  parameter int CAPACITY   = ils_pkg::CapacityDef,
  parameter int VALUE_BITS = ils_pkg::ValueBitsDef
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire ils_pkg::in_item_t in_item_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output ils_pkg::out_item_t     out_item_o
);

  import ils_pkg::*;

  ctrl_cmd_t ctrl_cmd;
  dp_stat_t  dp_stat;

  ils_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (dp_stat),
    .cmd_o      (ctrl_cmd)
  );

  ils_dpath #(
    .Capacity  (CAPACITY),
    .ValueBits (VALUE_BITS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o),
    .cmd_i       (ctrl_cmd),
    .stat_o      (dp_stat)
  );

endmodule

`default_nettype wire

// ===== tb/indexed_list_store_top_tb.sv =====
// Self-checking testbench for the indexed list store: directed and random commands against a list mirror.
`default_nettype none

module indexed_list_store_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ils_pkg::*;

  localparam int unsigned IdleLimit    = 5000;
  localparam int unsigned SettleCycles = 200;
  localparam int unsigned RandomItems  = 800;

  class list_mirror;
    logic [ItemW-1:0] slots [CapacityDef];
    int unsigned      used;
    out_item_t        awaited [$];
    int unsigned      errors;

    function new();
      used   = 0;
      errors = 0;
    endfunction

    function void open_gap(int unsigned at);
      for (int unsigned k = used; k > at; k--) slots[k] = slots[k-1];
    endfunction

    function void close_gap(int unsigned at);
      for (int unsigned k = at; k + 1 < used; k++) slots[k] = slots[k+1];
    endfunction

    function void note_command(in_item_t beat);
      cmd_e             op;
      int unsigned      pos;
      int unsigned      at;
      logic [ItemW-1:0] rd;
      status_e          st;
      out_item_t        exp;
      op  = cmd_e'(beat.cmd);
      pos = beat.position;
      rd  = '0;
      st  = ST_OK;
      case (op)
        CMD_PUSH, CMD_UNSHIFT: begin
          if (used >= CapacityDef) begin
            st = ST_FULL;
          end else begin
            at = (op == CMD_PUSH) ? used : 0;
            open_gap(at);
            slots[at] = beat.item_value;
            used++;
          end
        end
        CMD_POP: begin
          if (used == 0) begin
            st = ST_RANGE;
          end else begin
            used--;
            rd = slots[used];
          end
        end
        CMD_SHIFT: begin
          if (used == 0) begin
            st = ST_RANGE;
          end else begin
            rd = slots[0];
            close_gap(0);
            used--;
          end
        end
        CMD_FETCH: begin
          if (pos >= used) st = ST_RANGE;
          else rd = slots[pos];
        end
        CMD_UPDATE: begin
          if (pos >= used) st = ST_RANGE;
          else slots[pos] = beat.item_value;
        end
        CMD_INSERT: begin
          if (pos > used) begin
            st = ST_RANGE;
          end else if (used >= CapacityDef) begin
            st = ST_FULL;
          end else begin
            open_gap(pos);
            slots[pos] = beat.item_value;
            used++;
          end
        end
        default: begin
          if (pos >= used) begin
            st = ST_RANGE;
          end else begin
            close_gap(pos);
            used--;
          end
        end
      endcase
      exp.read_value = rd;
      exp.status     = st;
      exp.fill_count = used[FillW-1:0];
      awaited.push_back(exp);
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected result beat: read_value %h status %0d fill_count %0d",
                 $time, got.read_value, got.status, got.fill_count);
        errors++;
        return;
      end
      exp = awaited.pop_front();
      if (got.read_value !== exp.read_value) begin
        $display("%0t: read_value mismatch: expected %h, actual %h",
                 $time, exp.read_value, got.read_value);
        errors++;
      end
      if (got.status !== exp.status) begin
        $display("%0t: status mismatch: expected %0d, actual %0d",
                 $time, exp.status, got.status);
        errors++;
      end
      if (got.fill_count !== exp.fill_count) begin
        $display("%0t: fill_count mismatch: expected %0d, actual %0d",
                 $time, exp.fill_count, got.fill_count);
        errors++;
      end
    endfunction

    function int unsigned outstanding();
      return awaited.size();
    endfunction
  endclass

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_item_t  in_item_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_item_t out_item_o;

  list_mirror  mirror;
  bit          quiet;
  int unsigned idle_cycles;

  indexed_list_store_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic in_item_t mk(cmd_e op, int unsigned pos, logic [ItemW-1:0] val);
    in_item_t beat;
    beat.cmd        = op;
    beat.position   = pos[PosW-1:0];
    beat.item_value = val;
    return beat;
  endfunction

  function automatic in_item_t random_cmd(int unsigned grow_pct);
    in_item_t    beat;
    int unsigned held;
    held = mirror.used;
    if ($urandom_range(0, 99) < 20) begin
      beat.cmd = $urandom_range(0, 1) ? CMD_FETCH : CMD_UPDATE;
    end else if ($urandom_range(0, 99) < grow_pct) begin
      case ($urandom_range(0, 2))
        0:       beat.cmd = CMD_PUSH;
        1:       beat.cmd = CMD_UNSHIFT;
        default: beat.cmd = CMD_INSERT;
      endcase
    end else begin
      case ($urandom_range(0, 2))
        0:       beat.cmd = CMD_POP;
        1:       beat.cmd = CMD_SHIFT;
        default: beat.cmd = CMD_DELETE;
      endcase
    end
    if ($urandom_range(0, 4) == 0) beat.position = PosW'($urandom_range(0, CapacityDef));
    else beat.position = PosW'($urandom_range(0, held));
    case ($urandom_range(0, 9))
      0:       beat.item_value = '0;
      1:       beat.item_value = '1;
      default: beat.item_value = $urandom();
    endcase
    return beat;
  endfunction

  task automatic send_cmd(input in_item_t beat);
    int unsigned gap;
    gap = quiet ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= beat;
    do @(posedge clk_i); while (!in_ready_o);
    mirror.note_command(beat);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (mirror.outstanding() != 0);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && out_valid_o && out_ready_i) mirror.check_result(out_item_o);
  end

  always @(posedge clk_i) begin
    if (rst_ni !== 1'b1 || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    int unsigned stall;
    out_ready_i <= 1'b0;
    @(posedge clk_i);
    forever begin
      stall = quiet ? 0 : pick_gap();
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  end

  initial begin
    int unsigned sent;
    int unsigned phase;
    int unsigned span;
    int unsigned grow_pct;
    mirror      = new();
    quiet       = 1'b0;
    idle_cycles = 0;
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    in_item_i  <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_cmd(mk(CMD_POP,     0, '0));
    send_cmd(mk(CMD_SHIFT,   0, '0));
    send_cmd(mk(CMD_FETCH,   0, '0));
    send_cmd(mk(CMD_UPDATE,  0, 32'h1111_1111));
    send_cmd(mk(CMD_DELETE,  0, '0));
    send_cmd(mk(CMD_INSERT,  1, 32'h2222_2222));
    send_cmd(mk(CMD_INSERT,  0, '1));
    send_cmd(mk(CMD_PUSH,    0, '0));
    send_cmd(mk(CMD_UNSHIFT, 0, 32'h1234_5678));
    send_cmd(mk(CMD_INSERT,  1, 32'hA5A5_A5A5));
    send_cmd(mk(CMD_FETCH,   0, '0));
    send_cmd(mk(CMD_FETCH,   2, '0));
    send_cmd(mk(CMD_FETCH,   4, '0));
    send_cmd(mk(CMD_FETCH,   CapacityDef, '0));
    send_cmd(mk(CMD_UPDATE,  3, 32'h5A5A_5A5A));
    send_cmd(mk(CMD_FETCH,   3, '0));
    send_cmd(mk(CMD_DELETE,  1, '0));
    send_cmd(mk(CMD_DELETE,  3, '0));
    send_cmd(mk(CMD_INSERT,  4, 32'h3333_3333));
    send_cmd(mk(CMD_POP,     0, '0));
    send_cmd(mk(CMD_SHIFT,   0, '0));
    send_cmd(mk(CMD_FETCH,   0, '0));
    drain_results();

    sent  = 0;
    phase = 0;
    while (sent < RandomItems) begin
      case (phase % 4)
        0:       grow_pct = 95;
        1:       grow_pct = 50;
        2:       grow_pct = 5;
        default: grow_pct = 60;
      endcase
      quiet = ($urandom_range(0, 3) == 0);
      span  = $urandom_range(60, 140);
      for (int unsigned i = 0; i < span && sent < RandomItems; i++) begin
        send_cmd(random_cmd(grow_pct));
        sent++;
      end
      if (phase == 0) drain_results();
      phase++;
    end
    quiet = 1'b0;

    drain_results();
    repeat (SettleCycles) @(posedge clk_i);
    if (mirror.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
